[design/rmq_pkg.sv]
// Shared widths, defaults and branch codes for the rotation matrix to quaternion core.
package rmq_pkg;

    localparam int DATA_W        = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int BR_W          = 2;

    localparam logic [BR_W-1:0] BR_TRACE = 2'd0;
    localparam logic [BR_W-1:0] BR_X     = 2'd1;
    localparam logic [BR_W-1:0] BR_Y     = 2'd2;
    localparam logic [BR_W-1:0] BR_Z     = 2'd3;

endpackage

[design/rotation_matrix_to_quaternion_core.sv]
// Pipelined rotation matrix to quaternion conversion (four-branch trace method).
// Stages: decode register, square root chain, divide seed register, divide chain, output register.
// Throughput: one beat per cycle; the whole pipe holds while out_valid is high and
//   out_ready is low, set by the one-bit-per-stage root and divide chains.
// Reset: rst_n clears every valid bit asynchronously; payload registers are not reset.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] r00,
    input  logic signed [DATA_W-1:0] r01,
    input  logic signed [DATA_W-1:0] r02,
    input  logic signed [DATA_W-1:0] r10,
    input  logic signed [DATA_W-1:0] r11,
    input  logic signed [DATA_W-1:0] r12,
    input  logic signed [DATA_W-1:0] r20,
    input  logic signed [DATA_W-1:0] r21,
    input  logic signed [DATA_W-1:0] r22,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] qw,
    output logic signed [DATA_W-1:0] qx,
    output logic signed [DATA_W-1:0] qy,
    output logic signed [DATA_W-1:0] qz,
    output logic [BR_W-1:0]          branch_taken,
    output logic                     degenerate
);

    localparam int EXT_W  = DATA_W + 2;
    localparam int RAD_W  = ((FRAC_BITS > EXT_W - 1) ? FRAC_BITS : EXT_W - 1) + 2;
    localparam int SQ_W   = ((RAD_W - 1 + FRAC_BITS + 1) / 2) * 2;
    localparam int NS     = SQ_W / 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int NUM_W  = EXT_W + FRAC_BITS;
    localparam int ND     = NUM_W;
    localparam int QW     = FRAC_BITS + 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CW     = (ROOT_W > QW) ? ROOT_W : QW;

    localparam logic [CW-1:0] ONE_C   = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] POS_LIM = (FRAC_BITS >= DATA_W - 1) ? CW'(32767) : ONE_C;
    localparam logic [CW-1:0] NEG_LIM = (FRAC_BITS >= DATA_W - 1) ? CW'(32768) : ONE_C;

    logic en;

    // decode
    logic signed [EXT_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [EXT_W-1:0] trace;
    logic signed [RAD_W-1:0] one_s, rad;
    logic signed [EXT_W-1:0] n_dec [3];
    logic [BR_W-1:0]         br_dec;
    logic                    dg_dec;

    // square root stages, index 0 is the decode register
    logic [SQ_W-1:0]         sq_v_reg   [NS+1];
    logic [SQ_W:0]           sq_res_reg [NS+1];
    logic signed [EXT_W-1:0] sq_n_reg   [NS+1][3];
    logic [BR_W-1:0]         sq_br_reg  [NS+1];
    logic                    sq_dg_reg  [NS+1];
    logic                    sq_vld_reg [NS+1];
    logic [SQ_W-1:0]         sq_v_next   [NS+1];
    logic [SQ_W:0]           sq_res_next [NS+1];

    // divide stages, index 0 is the seed register
    logic [REM_W-1:0]        dv_rem_reg  [ND+1][3];
    logic [QW-1:0]           dv_q_reg    [ND+1][3];
    logic                    dv_ovf_reg  [ND+1][3];
    logic [NUM_W-1:0]        dv_num_reg  [ND+1][3];
    logic                    dv_neg_reg  [ND+1][3];
    logic [ROOT_W-1:0]       dv_root_reg [ND+1];
    logic [BR_W-1:0]         dv_br_reg   [ND+1];
    logic                    dv_dg_reg   [ND+1];
    logic                    dv_vld_reg  [ND+1];
    logic [REM_W-1:0]        dv_rem_next [ND+1][3];
    logic [QW-1:0]           dv_q_next   [ND+1][3];
    logic                    dv_ovf_next [ND+1][3];
    logic [NUM_W-1:0]        dv_num_next [ND+1][3];
    logic [ROOT_W-1:0]       root_fin;
    logic [NUM_W-1:0]        mag_seed    [3];

    // output
    logic [CW-1:0]           big_c;
    logic [DATA_W-1:0]       lane_s [3];
    logic [DATA_W-1:0]       big_s;
    logic [DATA_W-1:0]       q0_next, q1_next, q2_next, q3_next;
    logic [DATA_W-1:0]       q0_reg, q1_reg, q2_reg, q3_reg;
    logic [BR_W-1:0]         br_reg;
    logic                    dg_reg;
    logic                    vld_reg;

    assign en       = ~vld_reg | out_ready;
    assign in_ready = en;

    always_comb
    begin
        e00 = EXT_W'(r00); e01 = EXT_W'(r01); e02 = EXT_W'(r02);
        e10 = EXT_W'(r10); e11 = EXT_W'(r11); e12 = EXT_W'(r12);
        e20 = EXT_W'(r20); e21 = EXT_W'(r21); e22 = EXT_W'(r22);
        trace = e00 + e11 + e22;
        one_s = RAD_W'(1) << FRAC_BITS;
        if (trace > 0)
        begin
            br_dec   = BR_TRACE;
            rad      = one_s + RAD_W'(trace);
            n_dec[0] = e21 - e12;
            n_dec[1] = e02 - e20;
            n_dec[2] = e10 - e01;
        end
        else if (e00 > e11 && e00 > e22)
        begin
            br_dec   = BR_X;
            rad      = one_s + RAD_W'(e00) - RAD_W'(e11) - RAD_W'(e22);
            n_dec[0] = e21 - e12;
            n_dec[1] = e01 + e10;
            n_dec[2] = e02 + e20;
        end
        else if (e11 > e22)
        begin
            br_dec   = BR_Y;
            rad      = one_s + RAD_W'(e11) - RAD_W'(e00) - RAD_W'(e22);
            n_dec[0] = e02 - e20;
            n_dec[1] = e01 + e10;
            n_dec[2] = e12 + e21;
        end
        else
        begin
            br_dec   = BR_Z;
            rad      = one_s + RAD_W'(e22) - RAD_W'(e00) - RAD_W'(e11);
            n_dec[0] = e10 - e01;
            n_dec[1] = e02 + e20;
            n_dec[2] = e12 + e21;
        end
        dg_dec = (rad <= 0);
    end

    always_comb
    begin
        sq_v_next[0]   = '0;
        sq_res_next[0] = '0;
        for (int k = 1; k <= NS; k++)
        begin
            if ({1'b0, sq_v_reg[k-1]} >= sq_res_reg[k-1] + ((SQ_W+1)'(1) << (SQ_W - 2*k)))
            begin
                sq_v_next[k]   = sq_v_reg[k-1] - SQ_W'(sq_res_reg[k-1]
                                 + ((SQ_W+1)'(1) << (SQ_W - 2*k)));
                sq_res_next[k] = (sq_res_reg[k-1] >> 1) + ((SQ_W+1)'(1) << (SQ_W - 2*k));
            end
            else
            begin
                sq_v_next[k]   = sq_v_reg[k-1];
                sq_res_next[k] = sq_res_reg[k-1] >> 1;
            end
        end
    end

    assign root_fin = sq_res_reg[NS][ROOT_W-1:0];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mag_seed[l] = (NUM_W'(sq_n_reg[NS][l][EXT_W-1] ? -sq_n_reg[NS][l] : sq_n_reg[NS][l])
                           << FRAC_BITS) + NUM_W'(root_fin);
            dv_rem_next[0][l] = '0;
            dv_q_next[0][l]   = '0;
            dv_ovf_next[0][l] = 1'b0;
            dv_num_next[0][l] = '0;
        end
        for (int j = 1; j <= ND; j++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dv_num_next[j][l] = dv_num_reg[j-1][l] << 1;
                dv_ovf_next[j][l] = dv_ovf_reg[j-1][l] | dv_q_reg[j-1][l][QW-1];
                if ({dv_rem_reg[j-1][l][REM_W-2:0], dv_num_reg[j-1][l][NUM_W-1]}
                    >= {1'b0, dv_root_reg[j-1], 1'b0})
                begin
                    dv_rem_next[j][l] = {dv_rem_reg[j-1][l][REM_W-2:0],
                                         dv_num_reg[j-1][l][NUM_W-1]}
                                        - {1'b0, dv_root_reg[j-1], 1'b0};
                    dv_q_next[j][l]   = {dv_q_reg[j-1][l][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[j][l] = {dv_rem_reg[j-1][l][REM_W-2:0],
                                         dv_num_reg[j-1][l][NUM_W-1]};
                    dv_q_next[j][l]   = {dv_q_reg[j-1][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        big_c = CW'((({1'b0, dv_root_reg[ND]} + (ROOT_W+1)'(1)) >> 1));
        big_s = (big_c > POS_LIM) ? DATA_W'(POS_LIM) : DATA_W'(big_c);
        for (int l = 0; l < 3; l++)
        begin
            if (dv_neg_reg[ND][l])
            begin
                if (dv_ovf_reg[ND][l] || CW'(dv_q_reg[ND][l]) > NEG_LIM)
                    lane_s[l] = -DATA_W'(NEG_LIM);
                else
                    lane_s[l] = -DATA_W'(dv_q_reg[ND][l]);
            end
            else
            begin
                if (dv_ovf_reg[ND][l] || CW'(dv_q_reg[ND][l]) > POS_LIM)
                    lane_s[l] = DATA_W'(POS_LIM);
                else
                    lane_s[l] = DATA_W'(dv_q_reg[ND][l]);
            end
        end
        case (dv_br_reg[ND])
            BR_TRACE:
            begin
                q0_next = big_s;     q1_next = lane_s[0];
                q2_next = lane_s[1]; q3_next = lane_s[2];
            end
            BR_X:
            begin
                q0_next = lane_s[0]; q1_next = big_s;
                q2_next = lane_s[1]; q3_next = lane_s[2];
            end
            BR_Y:
            begin
                q0_next = lane_s[0]; q1_next = lane_s[1];
                q2_next = big_s;     q3_next = lane_s[2];
            end
            default:
            begin
                q0_next = lane_s[0]; q1_next = lane_s[1];
                q2_next = lane_s[2]; q3_next = big_s;
            end
        endcase
        if (dv_dg_reg[ND])
        begin
            q0_next = '0; q1_next = '0; q2_next = '0; q3_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int j = 0; j <= ND; j++)
                dv_vld_reg[j] <= 1'b0;
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= in_valid;
            for (int k = 1; k <= NS; k++)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            dv_vld_reg[0] <= sq_vld_reg[NS];
            for (int j = 1; j <= ND; j++)
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            vld_reg <= dv_vld_reg[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_v_reg[0]   <= dg_dec ? '0 : (SQ_W'(rad[RAD_W-2:0]) << FRAC_BITS);
            sq_res_reg[0] <= '0;
            sq_br_reg[0]  <= br_dec;
            sq_dg_reg[0]  <= dg_dec;
            for (int l = 0; l < 3; l++)
                sq_n_reg[0][l] <= n_dec[l];
            for (int k = 1; k <= NS; k++)
            begin
                sq_v_reg[k]   <= sq_v_next[k];
                sq_res_reg[k] <= sq_res_next[k];
                sq_br_reg[k]  <= sq_br_reg[k-1];
                sq_dg_reg[k]  <= sq_dg_reg[k-1];
                for (int l = 0; l < 3; l++)
                    sq_n_reg[k][l] <= sq_n_reg[k-1][l];
            end

            dv_root_reg[0] <= root_fin;
            dv_br_reg[0]   <= sq_br_reg[NS];
            dv_dg_reg[0]   <= sq_dg_reg[NS];
            for (int l = 0; l < 3; l++)
            begin
                dv_rem_reg[0][l] <= dv_rem_next[0][l];
                dv_q_reg[0][l]   <= dv_q_next[0][l];
                dv_ovf_reg[0][l] <= dv_ovf_next[0][l];
                dv_num_reg[0][l] <= mag_seed[l];
                dv_neg_reg[0][l] <= sq_n_reg[NS][l][EXT_W-1];
            end
            for (int j = 1; j <= ND; j++)
            begin
                dv_root_reg[j] <= dv_root_reg[j-1];
                dv_br_reg[j]   <= dv_br_reg[j-1];
                dv_dg_reg[j]   <= dv_dg_reg[j-1];
                for (int l = 0; l < 3; l++)
                begin
                    dv_rem_reg[j][l] <= dv_rem_next[j][l];
                    dv_q_reg[j][l]   <= dv_q_next[j][l];
                    dv_ovf_reg[j][l] <= dv_ovf_next[j][l];
                    dv_num_reg[j][l] <= dv_num_next[j][l];
                    dv_neg_reg[j][l] <= dv_neg_reg[j-1][l];
                end
            end

            q0_reg <= q0_next;
            q1_reg <= q1_next;
            q2_reg <= q2_next;
            q3_reg <= q3_next;
            br_reg <= dv_br_reg[ND];
            dg_reg <= dv_dg_reg[ND];
        end
    end

    assign out_valid    = vld_reg;
    assign qw           = q0_reg;
    assign qx           = q1_reg;
    assign qy           = q2_reg;
    assign qz           = q3_reg;
    assign branch_taken = br_reg;
    assign degenerate   = dg_reg;

endmodule

[design/rmq_checker.sv]
// Port-level checker for the rotation matrix to quaternion core, with its bind.
module rmq_checker
    import rmq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] qw,
    input logic signed [DATA_W-1:0] qx,
    input logic signed [DATA_W-1:0] qy,
    input logic signed [DATA_W-1:0] qz,
    input logic [BR_W-1:0]          branch_taken,
    input logic                     degenerate
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(qw) && $stable(branch_taken))
    else $error("result beat dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
    else $error("degenerate beat with nonzero quaternion");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_TRACE |-> !degenerate && qw > 0)
    else $error("trace branch gave degenerate or nonpositive qw");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);
